FILE: rtl/core/oll_pkg.sv
// oll_pkg: shared constants, opcodes, status codes and cell command type
// for the ordered list engine; no dependencies
package oll_pkg;

	// default sizing
	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	// fixed port widths
	localparam int OP_W    = 4;
	localparam int POS_W   = 5;
	localparam int IVAL_W  = 32;
	localparam int ST_W    = 3;
	localparam int FIDX_W  = 4;
	localparam int COUNT_W = 5;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
	localparam logic [OP_W-1:0] OP_APPEND     = 4'd1;
	localparam logic [OP_W-1:0] OP_INSERT_AT  = 4'd2;
	localparam logic [OP_W-1:0] OP_POP_HEAD   = 4'd3;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
	localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
	localparam logic [OP_W-1:0] OP_FIND       = 4'd6;
	localparam logic [OP_W-1:0] OP_READ_AT    = 4'd7;
	localparam logic [OP_W-1:0] OP_FRONT      = 4'd8;
	localparam logic [OP_W-1:0] OP_BACK       = 4'd9;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	// update command broadcast to every cell
	typedef struct packed {
		logic ins;       // open a gap at target and load the new value there
		logic del;       // close the gap, cells at or after the target pull from the right
		logic by_match;  // delete target is the first matching cell, not the index
	} oll_cmd_t;

endpackage

FILE: rtl/core/ordered_list_engine.sv
// ordered_list_engine: bounded ordered list of signed values built as a chain of cells
// top level; depends on oll_pkg and oll_cell
//
// The engine holds up to CAPACITY values in order, front at position 0, plus an entry
// count. Each item carries an opcode (push front/back, insert at, pop front/back, remove,
// find, read at, front, back, clear) and returns exactly one item with a status, any value
// read, any found index, the count after the operation and an empty flag. For each item, first
// the item is registered and every cell compares its entry with the item value and marks
// whether it is the read target; then the hit, first index and read value ripple along the
// cell chain, the status is resolved, all cells shift or load together and the result lands
// in the output register. A new item is taken the cycle after the previous one moves into
// the output register, so the engine cannot take a new item while one is still ahead of the
// output register; a stalled result holds the update step of the next item.
// Values are stored at VALUE_BITS bits; read values leave zero-extended or cut to 32 bits.
// Inserts into a full list are refused with the full status. No reset pass is needed:
// only positions below the count are ever compared or reported.
module ordered_list_engine
	import oll_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [OP_W-1:0]           opcode,
	input  logic [POS_W-1:0]          position,
	input  logic signed [IVAL_W-1:0]  item_value,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ST_W-1:0]           status,
	output logic signed [IVAL_W-1:0]  read_value,
	output logic [FIDX_W-1:0]         found_index,
	output logic [COUNT_W-1:0]        entry_count,
	output logic                      is_empty
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// handshakes
	logic accept;
	logic fire;

	// stage 1: registered item
	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [VALUE_BITS-1:0] val_s1;

	// list count
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	// output register
	logic                  out_valid_q;
	logic [ST_W-1:0]       status_q;
	logic [IVAL_W-1:0]     read_value_q;
	logic [FIDX_W-1:0]     found_index_q;
	logic [COUNT_W-1:0]    entry_count_q;
	logic                  is_empty_q;

	// item value sized to the storage width, sign carried when widening
	logic signed [VALUE_BITS+IVAL_W-1:0] in_val_w;
	logic [VALUE_BITS-1:0]               in_val;

	// read target chosen at accept time
	logic [CMP_W-1:0] in_pos_w;
	logic [CNT_W-1:0] back_cnt;
	logic [IDX_W-1:0] rd_addr;

	// chain wiring
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic                  hit_c      [CAPACITY+1];
	logic [IDX_W-1:0]      idx_c      [CAPACITY+1];
	logic [VALUE_BITS-1:0] rd_c       [CAPACITY+1];

	// stage 2 decode
	oll_cmd_t         cmd;
	logic [IDX_W-1:0] target;
	logic [ST_W-1:0]  st_nxt;
	logic             show_rd;
	logic             show_idx;
	logic             empty_s1;
	logic             full_s1;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;

	// output sizing
	logic [VALUE_BITS+IVAL_W-1:0] rd_w;
	logic [IDX_W+FIDX_W-1:0]      fidx_w;
	logic [CNT_W+COUNT_W-1:0]     cnt_out_w;

	// one item in flight ahead of the output register
	assign in_stall = valid_s1;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);

	assign in_val_w = (VALUE_BITS + IVAL_W)'(item_value);
	assign in_val   = in_val_w[VALUE_BITS-1:0];

	assign in_pos_w = CMP_W'(position);
	assign back_cnt = count_q - CNT_W'(1);

	always_comb begin
		rd_addr = '0;
		case (opcode)
			OP_READ_AT: rd_addr = in_pos_w[IDX_W-1:0];
			OP_BACK:    rd_addr = back_cnt[IDX_W-1:0];
			default:    rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			pos_s1 <= position;
			val_s1 <= in_val;
		end
	end

	// cell chain: hit, first index and read data ripple from front to back
	assign hit_c[0] = 1'b0;
	assign idx_c[0] = '0;
	assign rd_c[0]  = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v;
		logic [VALUE_BITS-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cell_value[i];
		end else begin : g_left
			assign left_v = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_right
			assign right_v = cell_value[i+1];
		end

		oll_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk         (clk),
			.load        (accept),
			.cmp_value   (in_val),
			.rd_addr     (rd_addr),
			.count       (count_q),
			.cmd         (cmd),
			.target      (target),
			.new_value   (val_s1),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[i]),
			.hit_in      (hit_c[i]),
			.idx_in      (idx_c[i]),
			.rd_in       (rd_c[i]),
			.hit_out     (hit_c[i+1]),
			.idx_out     (idx_c[i+1]),
			.rd_out      (rd_c[i+1])
		);
	end

	// stage 2: resolve status and drive the cell update
	assign empty_s1 = (count_q == '0);
	assign full_s1  = (count_q >= CAP_CNT);
	assign pos_w    = CMP_W'(pos_s1);
	assign cnt_w    = CMP_W'(count_q);

	always_comb begin
		st_nxt    = ST_OK;
		count_nxt = count_q;
		cmd       = '0;
		target    = '0;
		show_rd   = 1'b0;
		show_idx  = 1'b0;
		case (op_s1)
			OP_PUSH_FRONT: begin
				if (full_s1) begin
					st_nxt = ST_FULL;
				end else begin
					cmd.ins   = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_APPEND: begin
				if (full_s1) begin
					st_nxt = ST_FULL;
				end else begin
					cmd.ins   = 1'b1;
					target    = count_q[IDX_W-1:0];
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_INSERT_AT: begin
				if (pos_w > cnt_w) begin
					st_nxt = ST_RANGE;
				end else if (full_s1) begin
					st_nxt = ST_FULL;
				end else begin
					cmd.ins   = 1'b1;
					target    = pos_w[IDX_W-1:0];
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_POP_HEAD: begin
				if (empty_s1) begin
					st_nxt = ST_EMPTY;
				end else begin
					cmd.del   = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty_s1) begin
					st_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (empty_s1) begin
					st_nxt = ST_EMPTY;
				end else if (!hit_c[CAPACITY]) begin
					st_nxt = ST_NOTFOUND;
				end else begin
					cmd.del      = 1'b1;
					cmd.by_match = 1'b1;
					count_nxt    = count_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				if (empty_s1) begin
					st_nxt = ST_EMPTY;
				end else if (!hit_c[CAPACITY]) begin
					st_nxt = ST_NOTFOUND;
				end else begin
					show_idx = 1'b1;
				end
			end
			OP_READ_AT: begin
				if (pos_w >= cnt_w) begin
					st_nxt = ST_RANGE;
				end else begin
					show_rd = 1'b1;
				end
			end
			OP_FRONT, OP_BACK: begin
				if (empty_s1) begin
					st_nxt = ST_EMPTY;
				end else begin
					show_rd = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				st_nxt = ST_OK;
			end
		endcase
		// cells move only on the cycle the item completes
		if (!fire) begin
			cmd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nxt;
		end
	end

	// result sizing
	assign rd_w      = (VALUE_BITS + IVAL_W)'(rd_c[CAPACITY]);
	assign fidx_w    = (IDX_W + FIDX_W)'(idx_c[CAPACITY]);
	assign cnt_out_w = (CNT_W + COUNT_W)'(count_nxt);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= st_nxt;
			read_value_q  <= show_rd ? rd_w[IVAL_W-1:0] : '0;
			found_index_q <= show_idx ? fidx_w[FIDX_W-1:0] : '0;
			entry_count_q <= cnt_out_w[COUNT_W-1:0];
			is_empty_q    <= (count_nxt == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign found_index = found_index_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule

FILE: rtl/core/oll_cell.sv
// oll_cell: one storage cell of the ordered list chain
// holds one entry, compares it, and passes hit/index/read data to its right neighbor
// depends on oll_pkg
module oll_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 32,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  logic                  clk,
	// compare snapshot, taken when an item is accepted
	input  logic                  load,
	input  logic [VALUE_BITS-1:0] cmp_value,
	input  logic [IDX_W-1:0]      rd_addr,
	input  logic [CNT_W-1:0]      count,
	// update
	input  oll_pkg::oll_cmd_t     cmd,
	input  logic [IDX_W-1:0]      target,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [VALUE_BITS-1:0] value,
	// chain
	input  logic                  hit_in,
	input  logic [IDX_W-1:0]      idx_in,
	input  logic [VALUE_BITS-1:0] rd_in,
	output logic                  hit_out,
	output logic [IDX_W-1:0]      idx_out,
	output logic [VALUE_BITS-1:0] rd_out
);
	import oll_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

	logic [VALUE_BITS-1:0] value_q;
	logic                  match_q;
	logic                  pick_q;
	logic                  del_here;

	always_ff @(posedge clk) begin
		if (load) begin
			match_q <= (value_q == cmp_value) && (MY_CNT < count);
			pick_q  <= (MY_IDX == rd_addr);
		end
	end

	assign del_here = cmd.by_match ? (hit_in | match_q) : (MY_IDX >= target);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == target) begin
				value_q <= new_value;
			end else if (MY_IDX > target) begin
				value_q <= left_value;
			end
		end else if (cmd.del && del_here) begin
			value_q <= right_value;
		end
	end

	assign value   = value_q;
	assign hit_out = hit_in | match_q;
	assign idx_out = hit_in ? idx_in : MY_IDX;
	assign rd_out  = rd_in | (pick_q ? value_q : '0);

endmodule

FILE: rtl/core/oll_checker.sv
// oll_checker: port-level assertions for the ordered list engine, bound to the top level
// depends on oll_pkg and ordered_list_engine
module oll_checker #(
	parameter int CAPACITY = oll_pkg::CAPACITY_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [oll_pkg::ST_W-1:0]          status,
	input logic signed [oll_pkg::IVAL_W-1:0] read_value,
	input logic [oll_pkg::FIDX_W-1:0]        found_index,
	input logic [oll_pkg::COUNT_W-1:0]       entry_count,
	input logic                              is_empty
);
	import oll_pkg::*;

	// empty flag agrees with the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	// the count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(entry_count) <= CAPACITY))
		else $error("entry count beyond capacity");

	// a refused operation reports no data
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (read_value == '0 && found_index == '0))
		else $error("data reported with a failing status");

	// one item at a time: an accepted item blocks the input for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while one is in flight");

endmodule

bind ordered_list_engine oll_checker #(.CAPACITY(CAPACITY)) u_oll_checker (.*);
